// File: rtl/smro_pkg.sv
// shared types, widths and codes for the strided mixed-radix odometer
// used by smro_div and strided_mixed_radix_odometer_top; no dependencies
package smro_pkg;

  localparam int FUNC_W       = 2;
  localparam int WHEEL_SEL_W  = 3;
  localparam int ENTRY_W      = 11;
  localparam int WORD_W       = 11;
  localparam int RADIX_W      = 12;
  localparam int POS_W        = 5;
  localparam int START_W      = 32;
  localparam int DIGIT_W      = 11;
  localparam int DIV_W        = 32;
  localparam int CARRY_W      = 18;
  localparam int STRIDE_W     = 16;
  localparam int WCOUNT_W     = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int RESULT_LIMIT = 8;

  localparam int IN_DATA_W    = 80;
  localparam int OUT_DATA_W   = 16;

  // input beat layout inside s_axis_tdata
  localparam int WHEEL_SEL_LSB = 0;
  localparam int ENTRY_LSB     = WHEEL_SEL_LSB + WHEEL_SEL_W;
  localparam int WORD_LSB      = ENTRY_LSB + ENTRY_W;
  localparam int RADIX_LSB     = WORD_LSB + WORD_W;
  localparam int POS_LSB       = RADIX_LSB + RADIX_W;
  localparam int START_LSB     = POS_LSB + POS_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_START   = 2'd1,
    FUNC_ADVANCE = 2'd2
  } func_e;

  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY        = 2'd2;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_W-1:0]   quotient;
    logic [RADIX_W-1:0] remainder;
  } div_rsp_t;

endpackage

// File: rtl/smro_div.sv
// restoring divider, one quotient bit per cycle, shared by start and advance
// depends on smro_pkg for widths and the request/response structs
module smro_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smro_pkg::div_req_t  req_i,
  output smro_pkg::div_rsp_t  rsp_o
);

  localparam int DW    = smro_pkg::DIV_W;
  localparam int RW    = smro_pkg::RADIX_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]    quo_q, quo_d;
  logic [RW-1:0]    rem_q, rem_d;
  logic [RW-1:0]    dsr_q, dsr_d;

  logic [RW:0]      trial;
  logic [RW:0]      trial_sub;
  logic             ge;

  always_comb begin
    trial     = {rem_q, quo_q[DW-1]};
    ge        = trial >= {1'b0, dsr_q};
    trial_sub = trial - {1'b0, dsr_q};

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DW);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[DW-2:0], ge};
      // remainder stays below the divisor, so it fits the radix width
      rem_d = ge ? trial_sub[RW-1:0] : trial[RW-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: rtl/strided_mixed_radix_odometer_top.sv
// top level of the strided mixed-radix odometer: sequencer, wheel state, word table
// depends on smro_pkg and smro_div
//
// A load beat writes one word-table slot and the wheel's size and position and
// returns nothing. A start beat splits start_index into one digit per wheel in
// use, from the last wheel down to wheel 0, through the shared bit-serial divider;
// each wheel takes a launch, one divide step per quotient bit and a write-back.
// An advance beat adds the stride from the last wheel down and stops at the first
// wheel that takes no carry; a wheel that needs a divide goes through the divider,
// one that absorbs the carry does not. Readout then sends one beat per wheel in
// use from wheel 0, each through table read, output load and handshake, stalling
// while the sink is not ready; an exhausted counter answers with a single beat
// flagged in tuser. The block takes no new input beat until the last result beat
// is taken. The word table is a single memory of NW*MAX_RADIX words with no reset,
// NW = min(MAX_WHEELS, RESULT_LIMIT); slots never loaded read back undefined.
module strided_mixed_radix_odometer_top #(
  parameter int MAX_WHEELS = 8,
  parameter int MAX_RADIX  = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write port
  input  logic                                cfg_we_i,
  input  logic [smro_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [smro_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // wheel_sel, entry_index, word_value, radix_value, slot_position, start_index
  input  logic [smro_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // func
  input  logic [smro_pkg::FUNC_W-1:0]         s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_position, word_id
  output logic [smro_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // exhausted
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int NW    = (MAX_WHEELS < smro_pkg::RESULT_LIMIT) ? MAX_WHEELS
                                                               : smro_pkg::RESULT_LIMIT;
  localparam int WI    = (NW > 1) ? $clog2(NW) : 1;
  localparam int NCW   = $clog2(NW + 1);
  localparam int DEPTH = NW * MAX_RADIX;
  localparam int AW    = $clog2(DEPTH);

  localparam int DGW = smro_pkg::DIGIT_W;
  localparam int RW  = smro_pkg::RADIX_W;
  localparam int PW  = smro_pkg::POS_W;
  localparam int WW  = smro_pkg::WORD_W;
  localparam int CW  = smro_pkg::CARRY_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_SDIV  = 4'd2;
  localparam logic [3:0] ST_ADV   = 4'd3;
  localparam logic [3:0] ST_ADIV  = 4'd4;
  localparam logic [3:0] ST_RD    = 4'd5;
  localparam logic [3:0] ST_OUT   = 4'd6;
  localparam logic [3:0] ST_EXH   = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  logic [3:0]                       state_q, state_d;
  logic                             fin_q, fin_d;
  logic [smro_pkg::WCOUNT_W-1:0]    wcount_q, wcount_d;
  logic [smro_pkg::STRIDE_W-1:0]    stride_q, stride_d;
  logic                             gray_q, gray_d;
  logic [DGW-1:0]                   digits_q [NW];
  logic [DGW-1:0]                   digits_d [NW];
  logic [RW-1:0]                    radix_q  [NW];
  logic [RW-1:0]                    radix_d  [NW];
  logic [PW-1:0]                    pos_q    [NW];
  logic [PW-1:0]                    pos_d    [NW];
  logic [WI-1:0]                    k_q, k_d;
  logic                             parity_q, parity_d;
  logic                             m_valid_q, m_valid_d;

  logic [smro_pkg::START_W-1:0]     rest_q, rest_d;
  logic [CW-1:0]                    carry_q, carry_d;
  logic                             rd_ok_q, rd_ok_d;
  logic [smro_pkg::OUT_DATA_W-1:0]  m_data_q, m_data_d;
  logic                             m_exh_q, m_exh_d;
  logic                             m_last_q, m_last_d;

  logic [WW-1:0]                    wtab_mem [DEPTH];
  logic [WW-1:0]                    rd_data_q;
  logic                             wr_en, rd_en;
  logic [AW-1:0]                    wr_addr, rd_addr;

  smro_pkg::div_req_t               div_req;
  smro_pkg::div_rsp_t               div_rsp;

  logic [NCW-1:0]                   n_use;
  logic [WI-1:0]                    last_idx;
  logic                             in_fire;
  logic [smro_pkg::WHEEL_SEL_W-1:0] in_wsel;
  logic [smro_pkg::ENTRY_W-1:0]     in_entry;
  logic [WW-1:0]                    in_word;
  logic [RW-1:0]                    in_radix;
  logic [PW-1:0]                    in_pos;
  logic [smro_pkg::START_W-1:0]     in_start;
  logic [DGW-1:0]                   cur_d;
  logic [RW-1:0]                    cur_r;
  logic [CW-1:0]                    sum;
  logic [RW-1:0]                    refl;
  logic [RW-1:0]                    slot;
  logic                             slot_ok;

  smro_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign in_wsel  = s_axis_tdata[smro_pkg::WHEEL_SEL_LSB +: smro_pkg::WHEEL_SEL_W];
  assign in_entry = s_axis_tdata[smro_pkg::ENTRY_LSB +: smro_pkg::ENTRY_W];
  assign in_word  = s_axis_tdata[smro_pkg::WORD_LSB +: WW];
  assign in_radix = s_axis_tdata[smro_pkg::RADIX_LSB +: RW];
  assign in_pos   = s_axis_tdata[smro_pkg::POS_LSB +: PW];
  assign in_start = s_axis_tdata[smro_pkg::START_LSB +: smro_pkg::START_W];

  // zero wheels acts as one, anything above the wheel limit acts as the limit
  always_comb begin
    if (wcount_q == '0) begin
      n_use = NCW'(1);
    end else if (int'(wcount_q) > NW) begin
      n_use = NCW'(NW);
    end else begin
      n_use = NCW'(wcount_q);
    end
    last_idx = WI'(n_use - NCW'(1));
  end

  assign cur_d = digits_q[k_q];
  assign cur_r = radix_q[k_q];
  assign sum   = CW'(cur_d) + carry_q;

  // reflected digit; a stale digit at or above the radix reflects to slot 0
  always_comb begin
    refl    = (RW'(cur_d) < cur_r) ? (cur_r - RW'(1) - RW'(cur_d)) : '0;
    slot    = (gray_q && parity_q) ? refl : RW'(cur_d);
    slot_ok = int'(slot) < MAX_RADIX;
  end

  always_comb begin
    state_d   = state_q;
    fin_d     = fin_q;
    wcount_d  = wcount_q;
    stride_d  = stride_q;
    gray_d    = gray_q;
    digits_d  = digits_q;
    radix_d   = radix_q;
    pos_d     = pos_q;
    k_d       = k_q;
    parity_d  = parity_q;
    m_valid_d = m_valid_q;
    rest_d    = rest_q;
    carry_d   = carry_q;
    rd_ok_d   = rd_ok_q;
    m_data_d  = m_data_q;
    m_exh_d   = m_exh_q;
    m_last_d  = m_last_q;

    wr_en   = 1'b0;
    wr_addr = AW'(int'(in_wsel) * MAX_RADIX + int'(in_entry));
    rd_en   = 1'b0;
    rd_addr = AW'(int'(k_q) * MAX_RADIX + (slot_ok ? int'(slot) : 0));

    div_req.start    = 1'b0;
    div_req.dividend = rest_q;
    div_req.divisor  = cur_r;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        smro_pkg::CFG_WHEEL_COUNT: wcount_d = cfg_data_i[smro_pkg::WCOUNT_W-1:0];
        smro_pkg::CFG_STRIDE:      stride_d = cfg_data_i[smro_pkg::STRIDE_W-1:0];
        smro_pkg::CFG_GRAY:        gray_d   = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (smro_pkg::func_e'(s_axis_tuser))
            smro_pkg::FUNC_LOAD: begin
              if (int'(in_wsel) < NW) begin
                wr_en = int'(in_entry) < MAX_RADIX;
                radix_d[WI'(in_wsel)] = (int'(in_radix) > MAX_RADIX) ? RW'(MAX_RADIX)
                                                                     : in_radix;
                pos_d[WI'(in_wsel)]   = in_pos;
              end
            end
            smro_pkg::FUNC_START: begin
              for (int j = 0; j < NW; j++) begin
                digits_d[j] = '0;
              end
              fin_d   = 1'b0;
              rest_d  = in_start;
              k_d     = last_idx;
              state_d = ST_START;
            end
            smro_pkg::FUNC_ADVANCE: begin
              carry_d = CW'(stride_q);
              k_d     = last_idx;
              state_d = fin_q ? ST_EXH : ST_ADV;
            end
            default: ;
          endcase
        end
      end

      ST_START: begin
        if (cur_r == '0) begin
          fin_d   = 1'b1;
          state_d = ST_EXH;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_SDIV;
        end
      end

      ST_SDIV: begin
        if (div_rsp.done) begin
          digits_d[k_q] = DGW'(div_rsp.remainder);
          rest_d        = div_rsp.quotient;
          if (k_q == '0) begin
            if (div_rsp.quotient != '0) begin
              fin_d   = 1'b1;
              state_d = ST_EXH;
            end else begin
              parity_d = 1'b0;
              state_d  = ST_RD;
            end
          end else begin
            k_d     = k_q - WI'(1);
            state_d = ST_START;
          end
        end
      end

      ST_ADV: begin
        if (carry_q == '0) begin
          k_d      = '0;
          parity_d = 1'b0;
          state_d  = ST_RD;
        end else if (cur_r == '0) begin
          fin_d   = 1'b1;
          state_d = ST_EXH;
        end else if (sum < CW'(cur_r)) begin
          // wheel absorbs the carry, no divide needed
          digits_d[k_q] = DGW'(sum);
          carry_d       = '0;
          k_d           = '0;
          parity_d      = 1'b0;
          state_d       = ST_RD;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = smro_pkg::DIV_W'(sum);
          state_d          = ST_ADIV;
        end
      end

      ST_ADIV: begin
        if (div_rsp.done) begin
          digits_d[k_q] = DGW'(div_rsp.remainder);
          carry_d       = CW'(div_rsp.quotient);
          if (k_q == '0) begin
            if (div_rsp.quotient != '0) begin
              fin_d   = 1'b1;
              state_d = ST_EXH;
            end else begin
              parity_d = 1'b0;
              state_d  = ST_RD;
            end
          end else begin
            k_d     = k_q - WI'(1);
            state_d = ST_ADV;
          end
        end
      end

      ST_RD: begin
        rd_en    = 1'b1;
        rd_ok_d  = slot_ok;
        parity_d = parity_q ^ cur_d[0];
        state_d  = ST_OUT;
      end

      ST_OUT: begin
        m_valid_d = 1'b1;
        m_data_d  = {(rd_ok_q ? rd_data_q : WW'(0)), pos_q[k_q]};
        m_exh_d   = 1'b0;
        m_last_d  = (k_q == last_idx);
        state_d   = ST_EMIT;
      end

      ST_EXH: begin
        m_valid_d = 1'b1;
        m_data_d  = '0;
        m_exh_d   = 1'b1;
        m_last_d  = 1'b1;
        state_d   = ST_EMIT;
      end

      ST_EMIT: begin
        if (m_axis_tready) begin
          m_valid_d = 1'b0;
          if (m_last_q) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + WI'(1);
            state_d = ST_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fin_q     <= 1'b1;
      wcount_q  <= smro_pkg::WCOUNT_W'(1);
      stride_q  <= smro_pkg::STRIDE_W'(1);
      gray_q    <= 1'b0;
      k_q       <= '0;
      parity_q  <= 1'b0;
      m_valid_q <= 1'b0;
      for (int j = 0; j < NW; j++) begin
        digits_q[j] <= '0;
        radix_q[j]  <= '0;
        pos_q[j]    <= '0;
      end
    end else begin
      state_q   <= state_d;
      fin_q     <= fin_d;
      wcount_q  <= wcount_d;
      stride_q  <= stride_d;
      gray_q    <= gray_d;
      k_q       <= k_d;
      parity_q  <= parity_d;
      m_valid_q <= m_valid_d;
      digits_q  <= digits_d;
      radix_q   <= radix_d;
      pos_q     <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q   <= rest_d;
    carry_q  <= carry_d;
    rd_ok_q  <= rd_ok_d;
    m_data_q <= m_data_d;
    m_exh_q  <= m_exh_d;
    m_last_q <= m_last_d;
  end

  // word table: one write port for loads, one registered read port for readout
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wtab_mem[wr_addr] <= in_word;
    end
    if (rd_en) begin
      rd_data_q <= wtab_mem[rd_addr];
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_exh_q;
  assign m_axis_tlast  = m_last_q;

endmodule
